FILE: sv/md5bs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5bs_pkg
// Shared types, constants and round tables for the MD5 byte stream hasher.
// ----------------------------------------------------------------------------
package md5bs_pkg;

  // one queued item after classification
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       eom;
  } item_t;

  // head of the item queue as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

  // initial chaining value
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // per-round additive constants
  localparam logic [31:0] SINE_TAB [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // rotate amounts, indexed by group and round within the group mod 4
  localparam logic [4:0] ROT_TAB [4][4] = '{
    '{5'd7, 5'd12, 5'd17, 5'd22},
    '{5'd5, 5'd9,  5'd14, 5'd20},
    '{5'd4, 5'd11, 5'd16, 5'd23},
    '{5'd6, 5'd10, 5'd15, 5'd21}
  };

  // message word used by a round
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] i;
    logic [3:0] m;
    i = rnd[3:0];
    case (rnd[5:4])
      2'd0:    m = i;
      2'd1:    m = 4'((i << 2) + i + 4'd1);
      2'd2:    m = 4'((i << 1) + i + 4'd5);
      default: m = 4'((i << 3) - i);
    endcase
    return m;
  endfunction

endpackage

FILE: sv/md5bs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5bs_front
// Input front end: takes items, drops items that carry neither byte nor end
// of message, and queues the rest for the back end.
// ----------------------------------------------------------------------------
module md5bs_front #(
  parameter int Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  md5bs_pkg::item_t  in_item_i,
  input  logic              pop_i,
  output md5bs_pkg::queue_t q_o
);
  import md5bs_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  // classification: only items with an effect enter the queue
  assign in_ready_o = (cnt_q != CntW'(Depth));
  assign push = in_valid_i && in_ready_o && (in_item_i.has_byte || in_item_i.eom);
  assign pop  = pop_i && (cnt_q != '0);

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

  assign q_o.valid = (cnt_q != '0);
  assign q_o.item  = mem_q[rd_ptr_q];

endmodule

FILE: sv/md5bs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5bs_core
// Back end: packs bytes into the block, pads, runs the 64 rounds one per
// cycle, adds back into the chaining value and sends the digest words.
// ----------------------------------------------------------------------------
module md5bs_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  md5bs_pkg::queue_t q_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [31:0]       digest_word_o,
  output logic [1:0]        word_index_o,
  output logic              last_word_o
);
  import md5bs_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_PAD2  = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_ADD   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  // where to go once the block add-back is done
  typedef enum logic [1:0] {
    AFT_IDLE,
    AFT_PAD,
    AFT_PAD2,
    AFT_OUT
  } after_e;

  state_e      st_q, st_d;
  after_e      aft_q, aft_d;
  logic [31:0] blk_q  [16];
  logic [31:0] chain_q [4];
  logic [31:0] work_q [4];
  logic [63:0] count_q;
  logic [5:0]  round_q;
  logic [1:0]  idx_q;

  logic [5:0]  pos;
  logic [3:0]  pos_w;
  logic [1:0]  pos_l;
  logic        extra;
  logic [63:0] bit_len;
  logic [31:0] pad_word [16];
  logic [31:0] pad2_word [16];
  logic        load_work;

  logic [31:0] fa, fb, fc, fd, f_val, sum, rot_x, new_b;
  logic [63:0] rot_wide;
  logic [4:0]  rot_s;

  assign pos     = count_q[5:0];
  assign pos_w   = pos[5:2];
  assign pos_l   = pos[1:0];
  assign extra   = (pos[5:3] == 3'b111);
  assign bit_len = {count_q[60:0], 3'b000};

  // padded block words for the final and the extra length block
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      pad_word[k] = '0;
      if (4'(k) == pos_w) begin
        for (int l = 0; l < 4; l++) begin
          if (2'(l) < pos_l) begin
            pad_word[k][8*l +: 8] = blk_q[k][8*l +: 8];
          end else if (2'(l) == pos_l) begin
            pad_word[k][8*l +: 8] = PAD_BYTE;
          end
        end
      end else if (4'(k) < pos_w) begin
        pad_word[k] = blk_q[k];
      end
      pad2_word[k] = '0;
    end
    if (!extra) begin
      pad_word[14] = bit_len[31:0];
      pad_word[15] = bit_len[63:32];
    end
    pad2_word[14] = bit_len[31:0];
    pad2_word[15] = bit_len[63:32];
  end

  // one md5 round
  always_comb begin
    fa = work_q[0];
    fb = work_q[1];
    fc = work_q[2];
    fd = work_q[3];
    case (round_q[5:4])
      2'd0:    f_val = (fb & fc) | (~fb & fd);
      2'd1:    f_val = (fb & fd) | (fc & ~fd);
      2'd2:    f_val = fb ^ fc ^ fd;
      default: f_val = fc ^ (fb | ~fd);
    endcase
    sum      = fa + f_val + blk_q[msg_index(round_q)] + SINE_TAB[round_q];
    rot_s    = ROT_TAB[round_q[5:4]][round_q[1:0]];
    rot_wide = {sum, sum} << rot_s;
    rot_x    = rot_wide[63:32];
    new_b    = fb + rot_x;
  end

  // sequencer
  always_comb begin
    st_d      = st_q;
    aft_d     = aft_q;
    pop_o     = 1'b0;
    load_work = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (q_i.valid) begin
          pop_o = 1'b1;
          if (q_i.item.has_byte && (pos == 6'd63)) begin
            st_d      = ST_ROUND;
            aft_d     = q_i.item.eom ? AFT_PAD : AFT_IDLE;
            load_work = 1'b1;
          end else if (q_i.item.eom) begin
            st_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        st_d      = ST_ROUND;
        aft_d     = extra ? AFT_PAD2 : AFT_OUT;
        load_work = 1'b1;
      end
      ST_PAD2: begin
        st_d      = ST_ROUND;
        aft_d     = AFT_OUT;
        load_work = 1'b1;
      end
      ST_ROUND: begin
        if (round_q == 6'd63) begin
          st_d = ST_ADD;
        end
      end
      ST_ADD: begin
        unique case (aft_q)
          AFT_IDLE: st_d = ST_IDLE;
          AFT_PAD:  st_d = ST_PAD;
          AFT_PAD2: st_d = ST_PAD2;
          default:  st_d = ST_OUT;
        endcase
      end
      ST_OUT: begin
        if (out_ready_i && (idx_q == 2'd3)) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // control, chaining value, working registers and byte count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      aft_q      <= AFT_IDLE;
      round_q    <= '0;
      idx_q      <= '0;
      count_q    <= '0;
      chain_q[0] <= IV_A;
      chain_q[1] <= IV_B;
      chain_q[2] <= IV_C;
      chain_q[3] <= IV_D;
      for (int k = 0; k < 4; k++) begin
        work_q[k] <= '0;
      end
    end else begin
      st_q  <= st_d;
      aft_q <= aft_d;
      if ((st_q == ST_IDLE) && q_i.valid && q_i.item.has_byte) begin
        count_q <= count_q + 64'd1;
      end
      if (load_work) begin
        for (int k = 0; k < 4; k++) begin
          work_q[k] <= chain_q[k];
        end
      end
      if (st_q == ST_ROUND) begin
        work_q[0] <= fd;
        work_q[1] <= new_b;
        work_q[2] <= fb;
        work_q[3] <= fc;
        round_q   <= round_q + 6'd1;
      end
      if (st_q == ST_ADD) begin
        for (int k = 0; k < 4; k++) begin
          chain_q[k] <= chain_q[k] + work_q[k];
        end
      end
      if ((st_q == ST_OUT) && out_ready_i) begin
        idx_q <= idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          count_q    <= '0;
          chain_q[0] <= IV_A;
          chain_q[1] <= IV_B;
          chain_q[2] <= IV_C;
          chain_q[3] <= IV_D;
        end
      end
    end
  end

  // block buffer: byte lanes, then padding passes
  always_ff @(posedge clk_i) begin
    if ((st_q == ST_IDLE) && q_i.valid && q_i.item.has_byte) begin
      blk_q[pos_w][{pos_l, 3'b000} +: 8] <= q_i.item.data_byte;
    end
    if (st_q == ST_PAD) begin
      for (int k = 0; k < 16; k++) begin
        blk_q[k] <= pad_word[k];
      end
    end
    if (st_q == ST_PAD2) begin
      for (int k = 0; k < 16; k++) begin
        blk_q[k] <= pad2_word[k];
      end
    end
  end

  // digest words straight from the chaining value
  assign out_valid_o   = (st_q == ST_OUT);
  assign digest_word_o = chain_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == 2'd3);

endmodule

FILE: sv/md5_byte_stream_hasher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_byte_stream_hasher_unit
// MD5 over a byte stream: one byte per input transfer, four digest words
// per message.
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------------------------
//   in      | in_valid_i, in_ready_o | data_byte_i, byte_valid_i,
//           |                        | end_of_message_i
//   out     | out_valid_o,           | digest_word_o, word_index_o,
//           | out_ready_i            | last_word_o
//
// Each byte is written into the block; the byte that fills a block starts
// the rounds (64 rounds, one per cycle, then the add-back; the load shares
// the byte's cycle).
// The final item runs one or two padded blocks (each: a padding pass that
// loads the rounds, 64 rounds, add-back), then four output transfers.
// The item queue (QueueDepth entries) takes transfers while the round
// unit runs or the digest waits; in_ready_o drops only when it is full.
// Reset loads the initial chaining value and clears the byte count.
// ----------------------------------------------------------------------------
module md5_byte_stream_hasher_unit #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [1:0]  word_index_o,
  output logic        last_word_o
);
  import md5bs_pkg::*;

  item_t  in_item;
  queue_t q;
  logic   pop;

  assign in_item.data_byte = data_byte_i;
  assign in_item.has_byte  = byte_valid_i;
  assign in_item.eom       = end_of_message_i;

  // front end: classify and queue
  md5bs_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_item_i (in_item),
    .pop_i     (pop),
    .q_o       (q)
  );

  // back end: pack, pad, compress, emit
  md5bs_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_i          (q),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digest_word_o(digest_word_o),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o)
  );

endmodule
